// ----- design/sm4_pkg.sv -----
`timescale 1ns / 1ps

package sm4_pkg;

  localparam int Rounds   = 32;
  localparam int KeyIdxW  = $clog2(Rounds);
  localparam int NumStage = Rounds + 1;

  typedef enum logic [1:0] {
    MODE_ENC  = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef struct packed {
    logic        dec;
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau_sub(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mix_l(input logic [31:0] b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic stage_t sm4_round(input stage_t s, input logic [31:0] rk);
    stage_t r;
    r.dec = s.dec;
    r.x0  = s.x1;
    r.x1  = s.x2;
    r.x2  = s.x3;
    r.x3  = s.x0 ^ mix_l(tau_sub(s.x1 ^ s.x2 ^ s.x3 ^ rk));
    return r;
  endfunction

endpackage

// ----- design/sm4_in_if.sv -----
`timescale 1ns / 1ps

interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [4:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, mode, key_index, key_word, block_high, block_low,
                  input ready);
  modport sink   (input valid, mode, key_index, key_word, block_high, block_low,
                  output ready);
endinterface

// ----- design/sm4_out_if.sv -----
`timescale 1ns / 1ps

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ----- design/sm4_block_cipher_core.sv -----
`timescale 1ns / 1ps

// SM4 block cipher core, ECB, one 128-bit block per transaction.
// in_tx  : mode 0 encrypts, mode 1 decrypts block_high/block_low (big-endian);
//          mode 2 writes key_word into round key slot key_index, no result;
//          mode 3 is accepted and dropped.
// out_tx : result_high/result_low, one transaction per encrypt/decrypt.
// Pipeline: an input register plus one register stage per round (32) with
// the last stage doubling as output register. Throughput is one block per
// cycle while out_tx is not stalling the pipeline.
// A key load waits until no block is in flight (it needs the pipeline
// drained, including any output stall), then is taken.
// Reset clears all valid bits; round keys are undefined until loaded.
// When out_tx.ready is low with a result waiting, the whole pipeline holds
// and in_tx.ready drops; nothing is lost or repeated.
module sm4_block_cipher_core (
  input  logic         clk,
  input  logic         rst_n,
  sm4_in_if.sink       in_tx,
  sm4_out_if.source    out_tx
);

  localparam int NS = sm4_pkg::NumStage;

  logic [31:0]     rk_r   [sm4_pkg::Rounds];
  sm4_pkg::stage_t stg_r  [NS];
  sm4_pkg::stage_t stg_nxt[NS];
  logic [NS-1:0]   vld_r;
  logic [NS-1:0]   vld_nxt;
  logic            adv;
  logic            in_acc;
  logic            is_load;
  logic            is_blk;

  assign adv     = !vld_r[NS-1] || out_tx.ready;
  assign is_load = in_tx.mode == sm4_pkg::MODE_LOAD;
  assign is_blk  = in_tx.mode == sm4_pkg::MODE_ENC || in_tx.mode == sm4_pkg::MODE_DEC;
  assign in_tx.ready = adv && (!is_load || vld_r == '0);
  assign in_acc  = in_tx.valid && in_tx.ready;

  always_comb begin
    stg_nxt[0].dec = in_tx.mode == sm4_pkg::MODE_DEC;
    stg_nxt[0].x0  = in_tx.block_high[63:32];
    stg_nxt[0].x1  = in_tx.block_high[31:0];
    stg_nxt[0].x2  = in_tx.block_low[63:32];
    stg_nxt[0].x3  = in_tx.block_low[31:0];
    vld_nxt[0]     = in_acc && is_blk;
    for (int i = 1; i < NS; i++) begin
      stg_nxt[i] = sm4_pkg::sm4_round(stg_r[i-1],
                     stg_r[i-1].dec ? rk_r[sm4_pkg::KeyIdxW'(sm4_pkg::Rounds - i)]
                                    : rk_r[sm4_pkg::KeyIdxW'(i - 1)]);
      vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_load) begin
      rk_r[in_tx.key_index] <= in_tx.key_word;
    end
  end

  assign out_tx.valid       = vld_r[NS-1];
  assign out_tx.result_high = {stg_r[NS-1].x3, stg_r[NS-1].x2};
  assign out_tx.result_low  = {stg_r[NS-1].x1, stg_r[NS-1].x0};

`ifndef SYNTHESIS
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_load |-> vld_r == '0)
    else $error("key load taken with blocks in flight");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && !out_tx.ready |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_block_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_blk |=> vld_r[0])
    else $error("accepted block not in first stage");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");
`endif

endmodule
